FILE: sv/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LRF_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lrf_pkg.sv
package lrf_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int TAG_W      = 8;
    localparam int CFG_W      = 46;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOPE_W    = 32;
    localparam int ICPT_W     = 40;
    localparam int R2_W       = 17;
    localparam int STAT_W     = 2;
    localparam int PCNT_W     = 9;
    localparam int MUL_W      = 33;
    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 120;

    // Bit positions of the result word fields.
    localparam int M_SLOPE_LSB = 16;
    localparam int M_ICPT_LSB  = 48;
    localparam int M_R2_LSB    = 88;
    localparam int M_PCNT_LSB  = 105;

    // Fit status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DEGEN = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DROP  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEGEN_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_LIMIT  = 1'd1;

    localparam logic [R2_W-1:0] R2_ONE = 17'd65536;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE, ST_ACC_XY, ST_ACC_XX, ST_ACC_END,
        ST_D0, ST_D1, ST_D2, ST_D3, ST_N0, ST_N1, ST_N2, ST_CHECK,
        ST_SLOPE_DIV, ST_SLOPE_END, ST_K0, ST_K1, ST_K2,
        ST_ICPT_DIV, ST_ICPT_END, ST_NN0, ST_NN1, ST_NN2, ST_NN3,
        ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6, ST_W7,
        ST_R2, ST_R2_DIV, ST_R2_END, ST_FINISH
    } lrf_state_t;

    // Command to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     dq_init;
        logic [DIV_W-1:0]     divisor;
    } lrf_div_cmd_t;

endpackage

FILE: sv/lrf_ram.sv
module lrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/lrf_mul.sv
module lrf_mul (
    input  logic                          aclk,
    input  logic [lrf_pkg::MUL_W-1:0]     a,
    input  logic [lrf_pkg::MUL_W-1:0]     b,
    output logic signed [2*lrf_pkg::MUL_W-1:0] p
);

    // Signed multiply with the product registered.
    always_ff @(posedge aclk) begin
        p <= $signed(a) * $signed(b);
    end

endmodule

FILE: sv/lrf_div.sv
module lrf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrf_pkg::lrf_div_cmd_t        cmd,
    output logic [lrf_pkg::DIV_W-1:0]    quot,
    output logic                         done
);

    logic [lrf_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [lrf_pkg::DIV_W-1:0]     dq_reg, dq_next;
    logic [lrf_pkg::DIV_W-1:0]     div_reg;
    logic [lrf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg, done_reg;
    logic [lrf_pkg::DIV_W:0]       trial;
    logic                          fits;

    // One restoring step: shift the next dividend bit in, subtract if it fits.
    always_comb begin
        trial    = {rem_reg, dq_reg[lrf_pkg::DIV_W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? lrf_pkg::DIV_W'(trial - {1'b0, div_reg})
                        : trial[lrf_pkg::DIV_W-1:0];
        dq_next  = {dq_reg[lrf_pkg::DIV_W-2:0], fits};
    end

    // Control: iteration count, busy and a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lrf_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and combined dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg <= cmd.rem_init;
            dq_reg  <= cmd.dq_init;
            div_reg <= cmd.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quot = dq_reg;
    assign done = done_reg;

endmodule

FILE: sv/linear_regression_fit_unit.sv
// Least-squares line fit with R squared over up to MAX_POINTS probe points.
// Each point is accepted, then x*y and x*x are formed on the shared multiplier.
// A set of two or more then runs, as the fit needs, a 32-step slope division, a 64-step
// intercept division, a W0 to W7 state walk per stored point and a 17-step R2 division.
// The result waits in an output register; input is not accepted during a fit.
// aresetn is synchronous, active low; the point store is not cleared.
module linear_regression_fit_unit #(
    parameter int MAX_POINTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_sample[15:0], y_sample[31:16], source_id[39:32], dest_id[47:40]
    input  logic [lrf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // source_tag[7:0], dest_tag[15:8], slope[47:16], intercept[87:48],
    // r_squared[104:88], point_count[113:105], zero fill above
    output logic [lrf_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [lrf_pkg::STAT_W-1:0]      m_tuser,
    input  logic                            cfg_we,
    input  logic [lrf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lrf_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int SW     = lrf_pkg::SAMPLE_W;
    localparam int SX_W   = SW + CW;
    localparam int SXY_W  = 2 * SW + CW;
    localparam int MW     = lrf_pkg::MUL_W;
    localparam int THR_W  = 72;

    lrf_pkg::lrf_state_t state_reg, state_next;

    logic [lrf_pkg::CFG_W-1:0]  deg_lim_reg, flat_lim_reg;
    logic [CW-1:0]              count_reg, idx_reg;
    logic                       ovf_reg, take_reg, last_reg;
    logic signed [SW-1:0]       x_reg, y_reg;
    logic [lrf_pkg::TAG_W-1:0]  src_reg, dst_reg;
    logic signed [SX_W-1:0]     sum_x_reg, sum_y_reg;
    logic signed [SXY_W-1:0]    sum_xy_reg, sum_xx_reg;
    logic signed [63:0]         t0_reg, d_reg, nm_reg, num_reg, dy_reg, dx_reg;
    logic [63:0]                rm_reg, ss_t_reg, ss_r_reg;
    logic [2*CW-1:0]            nn_reg;
    logic [THR_W-1:0]           thr_reg;
    logic                       degen_reg, sneg_reg, ineg_reg;
    logic signed [lrf_pkg::SLOPE_W-1:0] k_reg;
    logic signed [lrf_pkg::ICPT_W-1:0]  icpt_reg;
    logic [lrf_pkg::R2_W-1:0]   r2_reg;
    logic [lrf_pkg::STAT_W-1:0] stat_reg;
    logic                       out_valid_reg;
    logic [lrf_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [lrf_pkg::STAT_W-1:0] out_user_reg;

    logic [MW-1:0]              mul_a, mul_b;
    logic signed [2*MW-1:0]     mul_p;
    lrf_pkg::lrf_div_cmd_t      div_cmd;
    logic [63:0]                div_q;
    logic                       div_done;
    logic                       ram_we, ram_re;
    logic [2*SW-1:0]            ram_rdata;

    logic                       s_accept, has_room, fin_go;
    logic signed [63:0]         p64, n64, sx64, sy64, sxy64, sxx64, sy16, res;
    logic [63:0]                d_mag, nm_mag, half_n, dy_mag, dy_sq, rm_sq, rm_new;
    logic                       degen, slope_sat, r2_go, r2_div;
    logic [46:0]                flat1;
    logic [32:0]                slope_mag;
    logic signed [lrf_pkg::SLOPE_W-1:0] k_sat, k_div;
    logic signed [lrf_pkg::ICPT_W-1:0]  icpt_div;
    logic [lrf_pkg::R2_W-1:0]   r2_div_val;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] usat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Shared units and the point store.
    lrf_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    lrf_div u_div (.aclk(aclk), .aresetn(aresetn), .cmd(div_cmd),
                   .quot(div_q), .done(div_done));

    lrf_ram #(.WIDTH(2 * SW), .DEPTH(MAX_POINTS)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(count_reg[AW-1:0]),
        .wdata(s_tdata[2*SW-1:0]), .re(ram_re), .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Derived values used by several states.
    always_comb begin
        p64       = mul_p[63:0];
        n64       = 64'(count_reg);
        sx64      = 64'(sum_x_reg);
        sy64      = 64'(sum_y_reg);
        sxy64     = 64'(sum_xy_reg);
        sxx64     = 64'(sum_xx_reg);
        sy16      = sy64 <<< 16;
        half_n    = n64 >> 1;
        d_mag     = mag64(d_reg);
        nm_mag    = mag64(nm_reg);
        degen     = (d_reg == 64'sd0) || (d_mag < 64'(deg_lim_reg));
        slope_sat = {15'b0, nm_mag} >= {d_mag, 15'b0};
        flat1     = 47'(flat_lim_reg) + 47'd1;
        dy_mag    = mag64(dy_reg);
        dy_sq     = (dy_mag > 64'hFFFF_FFFF) ? '1 : mul_p[63:0];
        rm_sq     = (rm_reg > 64'hFFFF_FFFF) ? '1 : mul_p[63:0];
        res       = (dy_reg <<< 16) - p64;
        rm_new    = (mag64(res) + 64'd32768) >> 16;
        r2_go     = THR_W'(ss_t_reg) >= thr_reg;
        r2_div    = r2_go && (ss_r_reg < ss_t_reg);
        has_room  = count_reg < CW'(MAX_POINTS);
        s_accept  = s_tvalid && s_tready;
        fin_go    = !out_valid_reg || m_tready;
    end

    // Slope from the division result, rounded and clamped to 32 bits.
    always_comb begin
        k_sat     = (nm_reg[63] ^ d_reg[63]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        slope_mag = ({1'b0, div_q[31:0]} + 33'd1) >> 1;
        if (!sneg_reg) begin
            k_div = (slope_mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(slope_mag);
        end else begin
            k_div = (slope_mag > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-slope_mag);
        end
    end

    // Intercept from the division result, clamped to 40 bits, and R squared from the quotient.
    always_comb begin
        if (!ineg_reg) begin
            icpt_div = (div_q > 64'h7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF : 40'(div_q);
        end else begin
            icpt_div = (div_q > 64'h80_0000_0000) ? 40'sh80_0000_0000 : 40'(-div_q);
        end
        r2_div_val = lrf_pkg::R2_ONE - 17'((18'(div_q[16:0]) + 18'd1) >> 1);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrf_pkg::ST_IDLE:    if (s_accept) state_next = lrf_pkg::ST_ACC_XY;
            lrf_pkg::ST_ACC_XY:  state_next = lrf_pkg::ST_ACC_XX;
            lrf_pkg::ST_ACC_XX:  state_next = lrf_pkg::ST_ACC_END;
            lrf_pkg::ST_ACC_END: begin
                if (!last_reg) state_next = lrf_pkg::ST_IDLE;
                else if (count_reg < CW'(2)) state_next = lrf_pkg::ST_FINISH;
                else state_next = lrf_pkg::ST_D0;
            end
            lrf_pkg::ST_D0:      state_next = lrf_pkg::ST_D1;
            lrf_pkg::ST_D1:      state_next = lrf_pkg::ST_D2;
            lrf_pkg::ST_D2:      state_next = lrf_pkg::ST_D3;
            lrf_pkg::ST_D3:      state_next = lrf_pkg::ST_N0;
            lrf_pkg::ST_N0:      state_next = lrf_pkg::ST_N1;
            lrf_pkg::ST_N1:      state_next = lrf_pkg::ST_N2;
            lrf_pkg::ST_N2:      state_next = lrf_pkg::ST_CHECK;
            lrf_pkg::ST_CHECK: begin
                if (degen) state_next = lrf_pkg::ST_ICPT_DIV;
                else if (slope_sat) state_next = lrf_pkg::ST_K0;
                else state_next = lrf_pkg::ST_SLOPE_DIV;
            end
            lrf_pkg::ST_SLOPE_DIV: if (div_done) state_next = lrf_pkg::ST_SLOPE_END;
            lrf_pkg::ST_SLOPE_END: state_next = lrf_pkg::ST_K0;
            lrf_pkg::ST_K0:      state_next = lrf_pkg::ST_K1;
            lrf_pkg::ST_K1:      state_next = lrf_pkg::ST_K2;
            lrf_pkg::ST_K2:      state_next = lrf_pkg::ST_ICPT_DIV;
            lrf_pkg::ST_ICPT_DIV: if (div_done) state_next = lrf_pkg::ST_ICPT_END;
            lrf_pkg::ST_ICPT_END:
                state_next = degen_reg ? lrf_pkg::ST_FINISH : lrf_pkg::ST_NN0;
            lrf_pkg::ST_NN0:     state_next = lrf_pkg::ST_NN1;
            lrf_pkg::ST_NN1:     state_next = lrf_pkg::ST_NN2;
            lrf_pkg::ST_NN2:     state_next = lrf_pkg::ST_NN3;
            lrf_pkg::ST_NN3:     state_next = lrf_pkg::ST_W0;
            lrf_pkg::ST_W0:      state_next = lrf_pkg::ST_W1;
            lrf_pkg::ST_W1:      state_next = lrf_pkg::ST_W2;
            lrf_pkg::ST_W2:      state_next = lrf_pkg::ST_W3;
            lrf_pkg::ST_W3:      state_next = lrf_pkg::ST_W4;
            lrf_pkg::ST_W4:      state_next = lrf_pkg::ST_W5;
            lrf_pkg::ST_W5:      state_next = lrf_pkg::ST_W6;
            lrf_pkg::ST_W6:      state_next = lrf_pkg::ST_W7;
            lrf_pkg::ST_W7: begin
                state_next = ((idx_reg + 1'b1) < count_reg) ? lrf_pkg::ST_W0
                                                            : lrf_pkg::ST_R2;
            end
            lrf_pkg::ST_R2:
                state_next = r2_div ? lrf_pkg::ST_R2_DIV : lrf_pkg::ST_FINISH;
            lrf_pkg::ST_R2_DIV:  if (div_done) state_next = lrf_pkg::ST_R2_END;
            lrf_pkg::ST_R2_END:  state_next = lrf_pkg::ST_FINISH;
            lrf_pkg::ST_FINISH:  if (fin_go) state_next = lrf_pkg::ST_IDLE;
            default:             state_next = lrf_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, store access, multiplier operands, divider command.
    always_comb begin
        s_tready = (state_reg == lrf_pkg::ST_IDLE);
        ram_we   = s_tvalid && (state_reg == lrf_pkg::ST_IDLE) && has_room;
        ram_re   = (state_reg == lrf_pkg::ST_W0);
        mul_a    = '0;
        mul_b    = '0;
        div_cmd  = '0;
        unique case (state_reg)
            lrf_pkg::ST_ACC_XY: begin mul_a = MW'(x_reg); mul_b = MW'(y_reg); end
            lrf_pkg::ST_ACC_XX: begin mul_a = MW'(x_reg); mul_b = MW'(x_reg); end
            lrf_pkg::ST_D0: begin mul_a = MW'(count_reg); mul_b = {1'b0, sxx64[31:0]}; end
            lrf_pkg::ST_D1: begin mul_a = MW'(count_reg); mul_b = MW'(sxx64 >>> 32); end
            lrf_pkg::ST_D2: begin mul_a = MW'(sum_x_reg); mul_b = MW'(sum_x_reg); end
            lrf_pkg::ST_D3: begin mul_a = MW'(count_reg); mul_b = {1'b0, sxy64[31:0]}; end
            lrf_pkg::ST_N0: begin mul_a = MW'(count_reg); mul_b = MW'(sxy64 >>> 32); end
            lrf_pkg::ST_N1: begin mul_a = MW'(sum_x_reg); mul_b = MW'(sum_y_reg); end
            lrf_pkg::ST_CHECK: begin
                if (degen) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.iters    = lrf_pkg::DIV_CNT_W'(64);
                    div_cmd.dq_init  = mag64(sy16) + half_n;
                    div_cmd.divisor  = n64;
                end else if (!slope_sat) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.iters    = lrf_pkg::DIV_CNT_W'(32);
                    div_cmd.rem_init = nm_mag >> 15;
                    div_cmd.dq_init  = {nm_mag[14:0], 49'b0};
                    div_cmd.divisor  = d_mag;
                end
            end
            lrf_pkg::ST_K0: begin mul_a = MW'(k_reg); mul_b = MW'(sum_x_reg); end
            lrf_pkg::ST_K2: begin
                div_cmd.start   = 1'b1;
                div_cmd.iters   = lrf_pkg::DIV_CNT_W'(64);
                div_cmd.dq_init = mag64(num_reg) + half_n;
                div_cmd.divisor = n64;
            end
            lrf_pkg::ST_NN0: begin mul_a = MW'(count_reg); mul_b = MW'(count_reg); end
            // The n*n product is still on the multiplier output here.
            lrf_pkg::ST_NN1: begin
                mul_a = MW'(mul_p[2*CW-1:0]);
                mul_b = {1'b0, flat1[31:0]};
            end
            lrf_pkg::ST_NN2: begin mul_a = MW'(nn_reg); mul_b = MW'(flat1[46:32]); end
            lrf_pkg::ST_W1: begin
                mul_a = MW'(count_reg);
                mul_b = MW'($signed(ram_rdata[2*SW-1:SW]));
            end
            lrf_pkg::ST_W2: begin
                mul_a = MW'(count_reg);
                mul_b = MW'($signed(ram_rdata[SW-1:0]));
            end
            lrf_pkg::ST_W3: begin mul_a = {1'b0, dy_mag[31:0]}; mul_b = {1'b0, dy_mag[31:0]}; end
            lrf_pkg::ST_W4: begin mul_a = MW'(k_reg); mul_b = MW'(dx_reg); end
            lrf_pkg::ST_W6: begin mul_a = {1'b0, rm_reg[31:0]}; mul_b = {1'b0, rm_reg[31:0]}; end
            lrf_pkg::ST_R2: begin
                if (r2_div) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.iters    = lrf_pkg::DIV_CNT_W'(17);
                    div_cmd.rem_init = ss_r_reg;
                    div_cmd.divisor  = ss_t_reg;
                end
            end
            default: ;
        endcase
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrf_pkg::ST_IDLE;
            deg_lim_reg   <= lrf_pkg::CFG_W'(1);
            flat_lim_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xy_reg    <= '0;
            sum_xx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    lrf_pkg::CFG_DEGEN_LIMIT: deg_lim_reg  <= cfg_wdata;
                    lrf_pkg::CFG_FLAT_LIMIT:  flat_lim_reg <= cfg_wdata;
                endcase
            end
            // Running sums of the current set.
            if (s_accept) begin
                if (has_room) begin
                    count_reg <= count_reg + 1'b1;
                    sum_x_reg <= sum_x_reg + SX_W'($signed(s_tdata[SW-1:0]));
                    sum_y_reg <= sum_y_reg + SX_W'($signed(s_tdata[2*SW-1:SW]));
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_reg == lrf_pkg::ST_ACC_XX && take_reg) begin
                sum_xy_reg <= sum_xy_reg + SXY_W'(p64);
            end
            if (state_reg == lrf_pkg::ST_ACC_END && take_reg) begin
                sum_xx_reg <= sum_xx_reg + SXY_W'(p64);
            end
            // Result hand-off clears the set.
            if (state_reg == lrf_pkg::ST_FINISH && fin_go) begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                sum_xy_reg    <= '0;
                sum_xx_reg    <= '0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Fit datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg    <= $signed(s_tdata[SW-1:0]);
            y_reg    <= $signed(s_tdata[2*SW-1:SW]);
            src_reg  <= s_tdata[39:32];
            dst_reg  <= s_tdata[47:40];
            last_reg <= s_tlast;
            take_reg <= has_room;
        end
        unique case (state_reg)
            lrf_pkg::ST_ACC_END: begin
                k_reg    <= '0;
                icpt_reg <= '0;
                r2_reg   <= '0;
                stat_reg <= (count_reg < CW'(2)) ? lrf_pkg::STAT_SHORT : lrf_pkg::STAT_OK;
            end
            lrf_pkg::ST_D0: ;
            lrf_pkg::ST_D1: t0_reg <= p64;
            lrf_pkg::ST_D2: t0_reg <= t0_reg + (p64 <<< 32);
            lrf_pkg::ST_D3: d_reg  <= t0_reg - p64;
            lrf_pkg::ST_N0: t0_reg <= p64;
            lrf_pkg::ST_N1: t0_reg <= t0_reg + (p64 <<< 32);
            lrf_pkg::ST_N2: nm_reg <= t0_reg - p64;
            lrf_pkg::ST_CHECK: begin
                degen_reg <= degen;
                sneg_reg  <= nm_reg[63] ^ d_reg[63];
                ineg_reg  <= sy64[63];
                if (degen) begin
                    stat_reg <= lrf_pkg::STAT_DEGEN;
                end else if (slope_sat) begin
                    k_reg <= k_sat;
                end
            end
            lrf_pkg::ST_SLOPE_END: k_reg <= k_div;
            lrf_pkg::ST_K1: num_reg <= sy16 - p64;
            lrf_pkg::ST_K2: ineg_reg <= num_reg[63];
            lrf_pkg::ST_ICPT_END: icpt_reg <= icpt_div;
            lrf_pkg::ST_NN1: nn_reg <= mul_p[2*CW-1:0];
            lrf_pkg::ST_NN2: thr_reg <= THR_W'(mul_p[63:0]);
            lrf_pkg::ST_NN3: begin
                thr_reg  <= thr_reg + (THR_W'(mul_p[63:0]) << 32);
                idx_reg  <= '0;
                ss_t_reg <= '0;
                ss_r_reg <= '0;
            end
            lrf_pkg::ST_W2: dy_reg <= p64 - sy64;
            lrf_pkg::ST_W3: dx_reg <= p64 - sx64;
            lrf_pkg::ST_W4: ss_t_reg <= usat_add(ss_t_reg, dy_sq);
            lrf_pkg::ST_W5: rm_reg <= rm_new;
            lrf_pkg::ST_W7: begin
                ss_r_reg <= usat_add(ss_r_reg, rm_sq);
                idx_reg  <= idx_reg + 1'b1;
            end
            lrf_pkg::ST_R2: begin
                stat_reg <= ovf_reg ? lrf_pkg::STAT_DROP : lrf_pkg::STAT_OK;
                if (!r2_go) begin
                    r2_reg <= lrf_pkg::R2_ONE;
                end else begin
                    r2_reg <= '0;
                end
            end
            lrf_pkg::ST_R2_END: r2_reg <= r2_div_val;
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (state_reg == lrf_pkg::ST_FINISH && fin_go) begin
            out_data_reg <= {6'b0, lrf_pkg::PCNT_W'(count_reg), r2_reg, icpt_reg, k_reg,
                             dst_reg, src_reg};
            out_user_reg <= stat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: sv/lrf_checker.sv
`include "assert_macros.svh"

module lrf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lrf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lrf_pkg::STAT_W-1:0]    m_tuser
);

    logic [lrf_pkg::SLOPE_W-1:0] slope_f;
    logic [lrf_pkg::R2_W-1:0]    r2_f;

    assign slope_f = m_tdata[lrf_pkg::M_SLOPE_LSB +: lrf_pkg::SLOPE_W];
    assign r2_f    = m_tdata[lrf_pkg::M_R2_LSB +: lrf_pkg::R2_W];

    // A stalled result word holds.
    `LRF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped or changed while stalled")

    // R squared never exceeds one.
    `LRF_ASSERT_IMPLY(a_r2_range, aclk, aresetn, m_tvalid, r2_f <= lrf_pkg::R2_ONE, "r_squared above 1.0")

    // Short and degenerate fits report a zero slope and zero R squared.
    `LRF_ASSERT_IMPLY(a_special_zero, aclk, aresetn, m_tvalid && (m_tuser == lrf_pkg::STAT_SHORT || m_tuser == lrf_pkg::STAT_DEGEN), slope_f == '0 && r2_f == '0, "special fit with nonzero slope or r_squared")

    // Input is not taken on back-to-back cycles: after any accepted word the input is not ready.
    `LRF_ASSERT_NEXT(a_busy_after_input, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken on back-to-back cycles")

endmodule

bind linear_regression_fit_unit lrf_checker u_lrf_checker (.*);

FILE: tb/sv/tb_linear_regression_fit_unit.sv
module tb_linear_regression_fit_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam longint unsigned POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned CFG_MAX = (64'd1 << lrf_pkg::CFG_W) - 64'd1;

    typedef struct {
        logic [lrf_pkg::TAG_W-1:0]   src;
        logic [lrf_pkg::TAG_W-1:0]   dst;
        logic [lrf_pkg::SLOPE_W-1:0] slope;
        logic [lrf_pkg::ICPT_W-1:0]  icpt;
        logic [lrf_pkg::R2_W-1:0]    r2;
        logic [lrf_pkg::STAT_W-1:0]  status;
        logic [lrf_pkg::PCNT_W-1:0]  npts;
    } fit_word_t;

    typedef struct {
        logic signed [lrf_pkg::SAMPLE_W-1:0] x;
        logic signed [lrf_pkg::SAMPLE_W-1:0] y;
        logic [lrf_pkg::TAG_W-1:0]           src;
        logic [lrf_pkg::TAG_W-1:0]           dst;
        bit                                  last;
        bit                                  typed;
        fit_word_t                           fit;
    } point_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [lrf_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [lrf_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [lrf_pkg::STAT_W-1:0]      m_tuser;
    logic                            cfg_we;
    logic [lrf_pkg::CFG_IDX_W-1:0]   cfg_addr;
    logic [lrf_pkg::CFG_W-1:0]       cfg_wdata;

    linear_regression_fit_unit DUT (.*);

    // Shadow of the fit engine state.
    longint          pt_x [CAPACITY];
    longint          pt_y [CAPACITY];
    int              pt_count;
    bit              pt_dropped;
    longint          acc_x, acc_y, acc_xy, acc_xx;
    longint unsigned degen_lim, flat_lim;

    fit_word_t fit_q[$];
    int        errors;
    int        gap_pct;
    int        stall_pct;
    int        hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned mag(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint clip_add(longint a, longint b);
        if (b > 0 && a > longint'(POS_LIM) - b) return longint'(POS_LIM);
        if (b < 0 && a < -longint'(POS_LIM) - b) return -longint'(POS_LIM);
        return a + b;
    endfunction

    function automatic longint clip_mul(longint a, longint b);
        longint unsigned ua, ub, p;
        ua = mag(a);
        ub = mag(b);
        if (ua == 0 || ub == 0) return 0;
        p = (ua > POS_LIM / ub) ? POS_LIM : ua * ub;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned uclip_add(longint unsigned a, longint unsigned b);
        return (a > ~64'd0 - b) ? ~64'd0 : a + b;
    endfunction

    function automatic longint unsigned usquare(longint unsigned m);
        return (m > 64'hFFFF_FFFF) ? ~64'd0 : m * m;
    endfunction

    // Binary fraction of rem / d, one bit per step, as the divider does it.
    function automatic longint unsigned div_fraction(longint unsigned rem,
                                                     longint unsigned d, int bits);
        longint unsigned q;
        q = 0;
        for (int i = 0; i < bits; i++) begin
            q = q << 1;
            if (rem >= d - rem) begin
                rem = rem - (d - rem);
                q = q | 64'd1;
            end else begin
                rem = rem << 1;
            end
        end
        return q;
    endfunction

    function automatic longint div_nearest(longint a, longint unsigned n);
        longint unsigned q;
        q = (mag(a) + n / 2) / n;
        return a < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_icpt(longint v);
        longint hi;
        hi = (longint'(1) << 39) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Adds one point to the set; on the last point returns 1 and the fit.
    function automatic bit fit_point(point_row_t p, output fit_word_t f);
        longint          n, den, num, k, icpt, dy, dx, res;
        longint unsigned r2, a, ad, ip, m, ss_tot, ss_res;
        logic [lrf_pkg::STAT_W-1:0] st;
        k = 0;
        icpt = 0;
        r2 = 0;
        if (pt_count < CAPACITY) begin
            pt_x[pt_count] = p.x;
            pt_y[pt_count] = p.y;
            pt_count++;
            acc_x  = clip_add(acc_x, longint'(p.x));
            acc_y  = clip_add(acc_y, longint'(p.y));
            acc_xy = clip_add(acc_xy, longint'(p.x) * longint'(p.y));
            acc_xx = clip_add(acc_xx, longint'(p.x) * longint'(p.x));
        end else begin
            pt_dropped = 1'b1;
        end
        if (!p.last) return 1'b0;
        n = pt_count;
        if (pt_count < 2) begin
            st = lrf_pkg::STAT_SHORT;
        end else begin
            den = clip_add(clip_mul(n, acc_xx), -clip_mul(acc_x, acc_x));
            if (den == 0 || mag(den) < degen_lim) begin
                st = lrf_pkg::STAT_DEGEN;
                icpt = clamp_icpt(div_nearest(clip_mul(acc_y, 65536), n));
            end else begin
                num = clip_add(clip_mul(n, acc_xy), -clip_mul(acc_x, acc_y));
                a = mag(num);
                ad = mag(den);
                ip = a / ad;
                if (ip >= 32768) m = ~64'd0;
                else m = (((ip << 17) | div_fraction(a % ad, ad, 17)) + 1) >> 1;
                if ((num < 0) != (den < 0)) begin
                    if (m > 64'h8000_0000) m = 64'h8000_0000;
                    k = -longint'(m);
                end else begin
                    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
                    k = longint'(m);
                end
                icpt = clamp_icpt(div_nearest(clip_add(clip_mul(acc_y, 65536),
                                                       -clip_mul(k, acc_x)), n));
                // Walk the stored points for the scaled square sums.
                ss_tot = 0;
                ss_res = 0;
                for (int i = 0; i < pt_count; i++) begin
                    dy = clip_add(clip_mul(n, pt_y[i]), -acc_y);
                    dx = clip_add(clip_mul(n, pt_x[i]), -acc_x);
                    res = clip_add(clip_mul(dy, 65536), -clip_mul(k, dx));
                    ss_tot = uclip_add(ss_tot, usquare(mag(dy)));
                    ss_res = uclip_add(ss_res, usquare((mag(res) + 32768) >> 16));
                end
                if (ss_tot / longint'(n * n) > flat_lim) begin
                    if (ss_res >= ss_tot) r2 = 0;
                    else r2 = 65536 - ((div_fraction(ss_res, ss_tot, 17) + 1) >> 1);
                end else begin
                    r2 = 65536;
                end
                st = pt_dropped ? lrf_pkg::STAT_DROP : lrf_pkg::STAT_OK;
            end
        end
        f.src    = p.src;
        f.dst    = p.dst;
        f.slope  = k[lrf_pkg::SLOPE_W-1:0];
        f.icpt   = icpt[lrf_pkg::ICPT_W-1:0];
        f.r2     = r2[lrf_pkg::R2_W-1:0];
        f.status = st;
        f.npts   = pt_count[lrf_pkg::PCNT_W-1:0];
        pt_count = 0;
        pt_dropped = 1'b0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: mismatch in %s, expected %0h, actual %0h",
                     $realtime, name, want, got);
            errors++;
        end
    endfunction

    // Offers one word, waits for the handshake and books the expected fit on a last point.
    task automatic send_point(point_row_t p);
        fit_word_t f;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.dst, p.src, p.y, p.x};
        s_tlast  <= p.last;
        do @(posedge aclk); while (!s_tready);
        if (fit_point(p, f)) fit_q.push_back(p.typed ? p.fit : f);
    endtask

    // One register write; the enable drops on the following cycle.
    task automatic write_reg(logic [lrf_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[lrf_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == lrf_pkg::CFG_DEGEN_LIMIT) degen_lim = val & CFG_MAX;
        else flat_lim = val & CFG_MAX;
    endtask

    // Lets every booked fit drain, then gives the engine time to settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (fit_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic signed [lrf_pkg::SAMPLE_W-1:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[lrf_pkg::SAMPLE_W-1:0];
    endfunction

    // Result side: check every accepted word, then choose the next ready.
    initial begin
        fit_word_t want;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (fit_q.size() == 0) begin
                    $display("%0t: unexpected fit word, actual %0h / %0h",
                             $realtime, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = fit_q.pop_front();
                    check_field("source_tag", want.src, m_tdata[lrf_pkg::TAG_W-1:0]);
                    check_field("dest_tag", want.dst,
                                m_tdata[2*lrf_pkg::TAG_W-1:lrf_pkg::TAG_W]);
                    check_field("slope", want.slope,
                                m_tdata[lrf_pkg::M_SLOPE_LSB +: lrf_pkg::SLOPE_W]);
                    check_field("intercept", want.icpt,
                                m_tdata[lrf_pkg::M_ICPT_LSB +: lrf_pkg::ICPT_W]);
                    check_field("r_squared", want.r2,
                                m_tdata[lrf_pkg::M_R2_LSB +: lrf_pkg::R2_W]);
                    check_field("status", want.status, m_tuser);
                    check_field("point_count", want.npts,
                                m_tdata[lrf_pkg::M_PCNT_LSB +: lrf_pkg::PCNT_W]);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        point_row_t rows[16];
        point_row_t p;
        int idle_gap[4];
        int idle_stall[4];
        longint unsigned degen_set[4];
        longint unsigned flat_set[4];
        int sent, size, kind, gain, big_left, x0, y0;

        idle_gap   = '{0, 0, 71, 15};
        idle_stall = '{0, 71, 0, 15};
        degen_set  = '{1, 0, CFG_MAX, 0};
        flat_set   = '{0, CFG_MAX, 0, 0};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = lrf_pkg::CFG_DEGEN_LIMIT;
        cfg_wdata = '0;
        errors    = 0;
        gap_pct   = 0;
        stall_pct = 0;
        hold_cycles = 0;
        pt_count  = 0;
        pt_dropped = 1'b0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        degen_lim = 1;
        flat_lim  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sets: single point, degenerate x, exact line, flat y, extremes.
        rows = '{
            '{0, 0, 8'h00, 8'hFF, 1, 1,
              '{8'h00, 8'hFF, 0, 0, 0, lrf_pkg::STAT_SHORT, 1}},
            '{5, 100, 8'h11, 8'h22, 0, 0, '{default: 0}},
            '{5, 300, 8'hA5, 8'h5A, 1, 1,
              '{8'hA5, 8'h5A, 0, 40'd13107200, 0, lrf_pkg::STAT_DEGEN, 2}},
            '{1, 2, 8'h01, 8'h02, 0, 0, '{default: 0}},
            '{2, 4, 8'h01, 8'h02, 0, 0, '{default: 0}},
            '{3, 6, 8'h01, 8'h02, 1, 1,
              '{8'h01, 8'h02, 32'd131072, 0, lrf_pkg::R2_ONE, lrf_pkg::STAT_OK, 3}},
            '{1, 5, 8'h03, 8'h04, 0, 0, '{default: 0}},
            '{2, 5, 8'h03, 8'h04, 1, 1,
              '{8'h03, 8'h04, 0, 40'd327680, lrf_pkg::R2_ONE, lrf_pkg::STAT_OK, 2}},
            '{-32768, 32767, 8'hFF, 8'h00, 0, 0, '{default: 0}},
            '{32767, -32768, 8'hFF, 8'h00, 1, 0, '{default: 0}},
            '{32767, 32767, 8'h80, 8'h7F, 0, 0, '{default: 0}},
            '{-32768, -32768, 8'h80, 8'h7F, 0, 0, '{default: 0}},
            '{0, -1, 8'h7F, 8'h80, 1, 0, '{default: 0}},
            '{-1, 0, 8'h55, 8'hAA, 0, 0, '{default: 0}},
            '{1, 0, 8'h55, 8'hAA, 0, 0, '{default: 0}},
            '{-32768, 1, 8'hAA, 8'h55, 1, 0, '{default: 0}}
        };
        foreach (rows[i]) send_point(rows[i]);

        // Random phases, each under its own register setting and idle pattern.
        big_left = 2;
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(lrf_pkg::CFG_DEGEN_LIMIT,
                      ph == 3 ? $urandom_range(0, 4000000) : degen_set[ph]);
            write_reg(lrf_pkg::CFG_FLAT_LIMIT,
                      ph == 3 ? $urandom_range(0, 20000) : flat_set[ph]);
            gap_pct   = idle_gap[ph];
            stall_pct = idle_stall[ph];
            if (ph == 1) hold_cycles = 3000;
            sent = 0;
            while (sent < 310) begin
                kind = $urandom_range(0, 99);
                if (kind < 4) size = 1;
                else if (kind < 6 && big_left > 0) begin
                    size = (big_left == 2) ? CAPACITY : CAPACITY + $urandom_range(1, 6);
                    big_left--;
                end else size = $urandom_range(2, 12);
                gain = $signed($urandom_range(0, 64)) - 32;
                x0 = $signed($urandom_range(0, 65535)) - 32768;
                y0 = $signed($urandom_range(0, 65535)) - 32768;
                for (int j = 0; j < size; j++) begin
                    p.x = $urandom;
                    p.y = $urandom;
                    p.src = $urandom;
                    p.dst = $urandom;
                    p.last = (j == size - 1);
                    p.typed = 1'b0;
                    p.fit = '{default: 0};
                    if (kind >= 50 && kind < 80) p.y = clip16((int'(p.x) * gain) / 16
                                                              + $signed($urandom_range(0, 200)) - 100);
                    else if (kind >= 80 && kind < 88) p.x = x0;
                    else if (kind >= 88 && kind < 94) p.y = y0;
                    send_point(p);
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0 && fit_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lrf_pkg.sv
sv/lrf_ram.sv
sv/lrf_mul.sv
sv/lrf_div.sv
sv/linear_regression_fit_unit.sv
sv/lrf_checker.sv
tb/sv/tb_linear_regression_fit_unit.sv
